// ----- hdl/tfrh_pkg.sv -----
// Package for the tagged FNV-1a 64-bit record hasher.
// Holds the word types, command codes, FNV constants and the byte-count table.
// No dependencies.
package tfrh_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3;
    localparam int unsigned FNV_PRIME_SHIFT = 40;

    localparam logic [7:0] TAG_U64  = 8'h55;
    localparam logic [7:0] TAG_BOOL = 8'h42;
    localparam logic [7:0] TAG_F32  = 8'h46;
    localparam logic [7:0] TAG_F64  = 8'h44;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_U64   = 3'd1;
    localparam logic [2:0] CMD_BOOL  = 3'd2;
    localparam logic [2:0] CMD_F32   = 3'd3;
    localparam logic [2:0] CMD_F64   = 3'd4;
    localparam logic [2:0] CMD_RAW8  = 3'd5;
    localparam logic [2:0] CMD_RAW1  = 3'd6;
    localparam logic [2:0] CMD_RAW4  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        side;
        logic [63:0] value;
        logic [15:0] count_add;
    } req_word_t;

    typedef struct packed {
        logic [63:0] hash_now;
        logic [31:0] count_now;
    } rsp_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free;
    } dp_sts_t;

    // Number of bytes folded by a command, tag byte included.
    function automatic logic [3:0] fold_len(input logic [2:0] cmd);
        logic [3:0] n;
        begin
            unique case (cmd)
                CMD_START: n = 4'd0;
                CMD_U64:   n = 4'd9;
                CMD_BOOL:  n = 4'd2;
                CMD_F32:   n = 4'd5;
                CMD_F64:   n = 4'd9;
                CMD_RAW8:  n = 4'd8;
                CMD_RAW1:  n = 4'd1;
                default:   n = 4'd4;
            endcase
            return n;
        end
    endfunction

endpackage

// ----- hdl/tagged_fnv1a64_record_hasher.sv -----
// Top level of the tagged FNV-1a 64-bit record hasher.
// Depends on tfrh_pkg, tfrh_ctrl and tfrh_dp.
//
// One request word is taken at a time. It folds n bytes (tag included) into the
// hash of the chosen side at one byte per cycle through a single xor-multiply
// step, then commits the result before the next word can be taken. n is 9 for
// u64 and f64, 8 for raw 8 bytes, 5 for f32, 4 for raw 4 bytes, 2 for bool, 1
// for one raw byte and 0 for start. The result sits in an output register, so
// a new word is taken while the previous result still waits; the block only
// holds in its final cycle when that register is still full.
module tagged_fnv1a64_record_hasher
    import tfrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    busy;

    assign req_stall = busy;

    tfrh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .sts       (dp_sts),
        .cmd       (dp_cmd),
        .busy      (busy)
    );

    tfrh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // A result is never written over one that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> (!rsp_valid || !rsp_stall))
        else $error("result overwritten while stalled");

    // An accepted word keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> busy)
        else $error("block idle right after accepting a word");

    // A new result appears only after a commit.
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(dp_cmd.commit))
        else $error("result valid without a commit");
`endif

endmodule

// ----- hdl/tfrh_ctrl.sv -----
// Controller of the record hasher: sequences load, byte folds and commit.
// Depends on tfrh_pkg.
module tfrh_ctrl
    import tfrh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [2:0] req_cmd,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] left_reg, left_next;
    logic [3:0] len;

    assign len  = fold_len(req_cmd);
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load  = 1'b1;
                    left_next = len;
                    state_next = (len == 4'd0) ? ST_FINISH : ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.step  = 1'b1;
                left_next = left_reg - 4'd1;
                if (left_reg == 4'd1)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ----- hdl/tfrh_dp.sv -----
// Datapath of the record hasher: hash and count state, byte shifter, FNV step
// and the result register. Depends on tfrh_pkg.
module tfrh_dp
    import tfrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_word_t req,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    logic [63:0] in_hash_reg, out_hash_reg;
    logic [31:0] in_count_reg, out_count_reg;
    logic [63:0] work_reg;
    logic [71:0] bytes_reg, bytes_next;
    logic        side_reg, start_reg;
    logic [15:0] add_reg;
    logic        valid_reg;
    rsp_word_t   rsp_reg;

    logic [63:0] mixed, folded;
    logic [31:0] count_sum;

    // Multiply by the FNV prime as a 40-bit shift plus a small product.
    assign mixed  = work_reg ^ {56'd0, bytes_reg[7:0]};
    assign folded = (mixed << FNV_PRIME_SHIFT) + (mixed * {55'd0, FNV_PRIME_LOW});

    assign count_sum = (side_reg ? out_count_reg : in_count_reg) + {16'd0, add_reg};

    assign sts.slot_free = !valid_reg || !rsp_stall;
    assign rsp_valid     = valid_reg;
    assign rsp           = rsp_reg;

    // Operand bytes in fold order, tag first where the command has one, low byte at the bottom.
    always_comb
    begin
        case (req.cmd)
            CMD_U64:  bytes_next = {req.value, TAG_U64};
            CMD_BOOL: bytes_next = {63'd0, |req.value, TAG_BOOL};
            CMD_F32:  bytes_next = {32'd0, req.value[31:0], TAG_F32};
            CMD_F64:  bytes_next = {req.value, TAG_F64};
            default:  bytes_next = {8'd0, req.value};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bytes_reg <= bytes_next;
            work_reg  <= req.side ? out_hash_reg : in_hash_reg;
            side_reg  <= req.side;
            start_reg <= (req.cmd == CMD_START);
            add_reg   <= req.count_add;
        end
        else if (cmd.step)
        begin
            bytes_reg <= {8'd0, bytes_reg[71:8]};
            work_reg  <= folded;
        end
        if (cmd.commit)
        begin
            if (start_reg)
            begin
                rsp_reg.hash_now  <= FNV_BASIS;
                rsp_reg.count_now <= 32'd0;
            end
            else
            begin
                rsp_reg.hash_now  <= work_reg;
                rsp_reg.count_now <= count_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hash_reg   <= FNV_BASIS;
            out_hash_reg  <= FNV_BASIS;
            in_count_reg  <= 32'd0;
            out_count_reg <= 32'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg <= 1'b1;
                if (start_reg)
                begin
                    in_hash_reg   <= FNV_BASIS;
                    out_hash_reg  <= FNV_BASIS;
                    in_count_reg  <= 32'd0;
                    out_count_reg <= 32'd0;
                end
                else if (side_reg)
                begin
                    out_hash_reg  <= work_reg;
                    out_count_reg <= count_sum;
                end
                else
                begin
                    in_hash_reg  <= work_reg;
                    in_count_reg <= count_sum;
                end
            end
            else if (valid_reg && !rsp_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
